@@ sv/smk_pkg.sv @@
package smk_pkg;

	localparam int DEF_ENTRIES  = 8;
	localparam int DEF_RELEASES = 2;
	localparam int TYPE_BITS    = 16;

	localparam logic [23:0] TIMEOUT_RESET = 24'd10000;
	localparam logic [15:0] HELD_BITS     = 16'h0007;

	typedef enum logic [2:0] {
		FUNC_PRESS    = 3'd0,
		FUNC_RELEASE  = 3'd1,
		FUNC_TICK     = 3'd2,
		FUNC_ADD      = 3'd3,
		FUNC_ADD_REL  = 3'd4,
		FUNC_RESET_ST = 3'd5,
		FUNC_CLEAR    = 3'd6,
		FUNC_NOP      = 3'd7
	} func_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_MATCH = 2'd1,
		ST_FULL     = 2'd2,
		ST_REL_FULL = 2'd3
	} status_e;

	typedef struct packed {
		func_e       func;
		logic [15:0] keycode;
		logic [2:0]  held_modifiers;
		logic [3:0]  entry_type;
		logic [15:0] entry_mask;
		logic        entry_toggle;
	} req_t;

	typedef struct packed {
		status_e     status;
		logic [15:0] modifier_state;
		logic        any_toggled;
	} rsp_t;

	// broadcast from control to every cell
	typedef struct packed {
		logic        go;
		func_e       func;
		logic [15:0] keycode;
		logic [15:0] match_mods;
		logic [3:0]  entry_type;
		logic [15:0] entry_mask;
		logic        entry_toggle;
		logic        clr_latch;
	} ctrl_t;

	// rippled from cell to cell
	typedef struct packed {
		logic [15:0] mods;
		logic        any_tog;
		logic        found;
		logic        hit_tog;
		logic        hit_latch;
		logic        last_full;
	} link_t;

	function automatic logic [15:0] type_mask(input logic [3:0] idx);
		logic [15:0] m;
		m = '0;
		if ({28'd0, idx} < 32'(TYPE_BITS)) begin
			m = 16'd1 << idx;
		end
		return m;
	endfunction

endpackage

@@ sv/smk_cell.sv @@
module smk_cell #(
	parameter int RELEASES = smk_pkg::DEF_RELEASES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  smk_pkg::ctrl_t ctrl,
	input  logic           add_sel,
	input  logic           rel_sel,
	input  smk_pkg::link_t link_in,
	output smk_pkg::link_t link_out
);
	import smk_pkg::*;

	localparam int RCW = $clog2(RELEASES + 1);
	localparam int RIW = (RELEASES > 1) ? $clog2(RELEASES) : 1;

	logic                 valid_q;
	logic                 pressed_q;
	logic                 latched_q;
	logic [RCW-1:0]       rel_cnt_q;
	logic [15:0]          key_q;
	logic [15:0]          need_q;
	logic [3:0]           type_q;
	logic                 tog_q;
	logic [RELEASES-1:0][15:0] rel_keys_q;

	logic own_full;
	logic match;
	logic take;
	logic rel_hit;
	logic active;

	assign own_full = (rel_cnt_q >= RCW'(RELEASES));
	assign match    = valid_q && (key_q == ctrl.keycode)
		&& ((need_q & ctrl.match_mods) == need_q);
	assign take     = match && !link_in.found;
	assign active   = valid_q && (pressed_q || latched_q);

	always_comb begin
		rel_hit = 1'b0;
		for (int j = 0; j < RELEASES; j++) begin
			if ((RCW'(j) < rel_cnt_q) && (rel_keys_q[j] == ctrl.keycode)) begin
				rel_hit = 1'b1;
			end
		end
	end

	always_comb begin
		link_out           = link_in;
		link_out.mods      = link_in.mods | (active ? type_mask(type_q) : 16'd0);
		link_out.any_tog   = link_in.any_tog || (valid_q && tog_q && latched_q);
		link_out.last_full = rel_sel ? own_full : link_in.last_full;
		if (take) begin
			link_out.found     = 1'b1;
			link_out.hit_tog   = tog_q;
			link_out.hit_latch = !latched_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			pressed_q <= 1'b0;
			latched_q <= 1'b0;
			rel_cnt_q <= '0;
		end else if (ctrl.go) begin
			case (ctrl.func)
				FUNC_PRESS: begin
					if (take) begin
						pressed_q <= 1'b1;
						if (tog_q) begin
							latched_q <= !latched_q;
						end
					end
				end
				FUNC_RELEASE: begin
					if (valid_q && rel_hit) begin
						pressed_q <= 1'b0;
					end
				end
				FUNC_TICK: begin
					if (ctrl.clr_latch) begin
						latched_q <= 1'b0;
					end
				end
				FUNC_ADD: begin
					if (add_sel) begin
						valid_q   <= 1'b1;
						pressed_q <= 1'b0;
						latched_q <= 1'b0;
						rel_cnt_q <= RCW'(1);
					end
				end
				FUNC_ADD_REL: begin
					if (rel_sel && !own_full) begin
						rel_cnt_q <= rel_cnt_q + RCW'(1);
					end
				end
				FUNC_RESET_ST: begin
					pressed_q <= 1'b0;
					latched_q <= 1'b0;
				end
				FUNC_CLEAR: begin
					valid_q   <= 1'b0;
					pressed_q <= 1'b0;
					latched_q <= 1'b0;
					rel_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go && (ctrl.func == FUNC_ADD) && add_sel) begin
			key_q         <= ctrl.keycode;
			need_q        <= ctrl.entry_mask;
			type_q        <= ctrl.entry_type;
			tog_q         <= ctrl.entry_toggle;
			rel_keys_q[0] <= ctrl.keycode;
		end else if (ctrl.go && (ctrl.func == FUNC_ADD_REL) && rel_sel && !own_full) begin
			rel_keys_q[rel_cnt_q[RIW-1:0]] <= ctrl.keycode;
		end
	end

endmodule

@@ sv/sticky_modifier_key_tracker_unit.sv @@
// channel | signals                    | word
// --------+----------------------------+-------
// req     | req_valid, req_stall, req  | req_t
// rsp     | rsp_valid, rsp_stall, rsp  | rsp_t
// cfg     | cfg_wr_en, cfg_wr_data     | 24 bit toggle timeout
//
// For each word the cell row updates at accept, then the
// result is read off the end of the row into the output register.
// req_stall is high from accept until the result is loaded; a stalled rsp
// holds the next request back. Reset empties the table and stops the timer;
// no clearing pass is needed.
module sticky_modifier_key_tracker_unit #(
	parameter int ENTRIES  = smk_pkg::DEF_ENTRIES,
	parameter int RELEASES = smk_pkg::DEF_RELEASES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  smk_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output smk_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic [23:0]   cfg_wr_data
);
	import smk_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	logic [23:0]   timeout_q;
	logic [23:0]   timer_q;
	logic          running_q;
	logic [CW-1:0] count_q;
	logic          pending_q;
	status_e       status_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;
	logic [15:0]   mods_q;

	logic          acc;
	logic          load;
	logic          full;
	ctrl_t         ctrl;
	status_e       status_d;
	link_t         links [ENTRIES+1];

	assign acc       = req_valid && !pending_q;
	assign req_stall = pending_q;
	assign load      = pending_q && (!rsp_valid_q || !rsp_stall);
	assign full      = (count_q == CW'(ENTRIES));
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign links[0]  = '0;

	// modifier state only moves at accept, so the copy taken at load is current
	always_comb begin
		ctrl.go           = acc;
		ctrl.func         = req.func;
		ctrl.keycode      = req.keycode;
		ctrl.match_mods   = (mods_q & ~HELD_BITS) | {13'd0, req.held_modifiers};
		ctrl.entry_type   = req.entry_type;
		ctrl.entry_mask   = req.entry_mask;
		ctrl.entry_toggle = req.entry_toggle;
		ctrl.clr_latch    = running_q && (timer_q <= 24'd1);
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		smk_cell #(
			.RELEASES(RELEASES)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.add_sel  (count_q == CW'(i)),
			.rel_sel  (count_q == CW'(i + 1)),
			.link_in  (links[i]),
			.link_out (links[i+1])
		);
	end

	always_comb begin
		status_d = ST_OK;
		case (req.func)
			FUNC_PRESS: begin
				if (!links[ENTRIES].found) begin
					status_d = ST_NO_MATCH;
				end
			end
			FUNC_ADD: begin
				if (full) begin
					status_d = ST_FULL;
				end
			end
			FUNC_ADD_REL: begin
				if (count_q == '0) begin
					status_d = ST_NO_MATCH;
				end else if (links[ENTRIES].last_full) begin
					status_d = ST_REL_FULL;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mods_q <= '0;
		end else if (load) begin
			mods_q <= links[ENTRIES].mods;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= '0;
			running_q <= 1'b0;
			count_q   <= '0;
		end else if (acc) begin
			case (req.func)
				FUNC_PRESS: begin
					if (links[ENTRIES].found && links[ENTRIES].hit_tog) begin
						if (links[ENTRIES].hit_latch) begin
							if (timeout_q != '0) begin
								timer_q   <= timeout_q;
								running_q <= 1'b1;
							end
						end else begin
							timer_q   <= '0;
							running_q <= 1'b0;
						end
					end
				end
				FUNC_TICK: begin
					if (ctrl.clr_latch) begin
						timer_q   <= '0;
						running_q <= 1'b0;
					end else if (running_q) begin
						timer_q <= timer_q - 24'd1;
					end
				end
				FUNC_ADD: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end
				FUNC_RESET_ST: begin
					timer_q   <= '0;
					running_q <= 1'b0;
				end
				FUNC_CLEAR: begin
					timer_q   <= '0;
					running_q <= 1'b0;
					count_q   <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				pending_q <= 1'b1;
			end else if (load) begin
				pending_q <= 1'b0;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= status_d;
		end
		if (load) begin
			rsp_q.status         <= status_q;
			rsp_q.modifier_state <= links[ENTRIES].mods;
			rsp_q.any_toggled    <= links[ENTRIES].any_tog;
		end
	end

	a_acc_pending: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> pending_q)
		else $error("accepted word did not mark pending");

	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (rsp_valid_q && !pending_q))
		else $error("result load did not present word");

	a_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (timer_q != '0))
		else $error("timer running at zero");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("entry count beyond table");

endmodule

@@ bench/smk_result_checker.sv @@
`timescale 1ns / 1ps

module smk_result_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_stall,
	input  smk_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_stall,
	input  smk_pkg::rsp_t rsp,
	input  logic          cfg_wr_en,
	input  logic [23:0]   cfg_wr_data,
	output int            errors,
	output int            outstanding
);
	import smk_pkg::*;

	localparam int NE = DEF_ENTRIES;
	localparam int NR = DEF_RELEASES;

	logic [23:0]   timeout;
	logic [NE-1:0] ent_valid;
	logic [NE-1:0] ent_tog;
	logic [NE-1:0] ent_pressed;
	logic [NE-1:0] ent_latched;
	logic [15:0]   ent_key [NE];
	logic [15:0]   ent_need [NE];
	logic [3:0]    ent_type [NE];
	logic [15:0]   rel_key [NE][NR];
	int            rel_cnt [NE];
	int            n_entries;
	logic [23:0]   tmr;
	logic          tmr_on;

	rsp_t expected_words[$];
	rsp_t want;

	initial errors = 0;

	task report_mismatch(input string msg);
		$display("checker: %s", msg);
		errors++;
	endtask

	function automatic logic [15:0] active_mods();
		logic [15:0] s;
		s = '0;
		for (int e = 0; e < NE; e++) begin
			if (ent_valid[e] && (ent_pressed[e] || ent_latched[e]) && ent_type[e] < TYPE_BITS) begin
				s |= 16'd1 << ent_type[e];
			end
		end
		return s;
	endfunction

	function automatic void drop_latches();
		ent_latched = '0;
		tmr_on = 1'b0;
		tmr = '0;
	endfunction

	function automatic void clear_table();
		ent_valid = '0;
		ent_tog = '0;
		ent_pressed = '0;
		for (int e = 0; e < NE; e++) begin
			rel_cnt[e] = 0;
		end
		n_entries = 0;
		drop_latches();
	endfunction

	// advance the tracker state by one word and return its result
	function automatic rsp_t track_word(input req_t w);
		rsp_t r;
		logic [15:0] s;
		logic hit;
		int n;
		r.status = ST_OK;
		case (w.func)
			FUNC_PRESS: begin
				s = active_mods();
				s[2:0] = w.held_modifiers;
				hit = 1'b0;
				for (int e = 0; e < NE; e++) begin
					if (!hit && ent_valid[e] && ent_key[e] == w.keycode &&
							(ent_need[e] & s) == ent_need[e]) begin
						hit = 1'b1;
						ent_pressed[e] = 1'b1;
						if (ent_tog[e]) begin
							ent_latched[e] = !ent_latched[e];
							if (ent_latched[e]) begin
								if (timeout != 0) begin
									tmr = timeout;
									tmr_on = 1'b1;
								end
							end else begin
								tmr_on = 1'b0;
								tmr = '0;
							end
						end
					end
				end
				if (!hit) begin
					r.status = ST_NO_MATCH;
				end
			end
			FUNC_RELEASE: begin
				for (int e = 0; e < NE; e++) begin
					for (int i = 0; i < rel_cnt[e]; i++) begin
						if (ent_valid[e] && rel_key[e][i] == w.keycode) begin
							ent_pressed[e] = 1'b0;
						end
					end
				end
			end
			FUNC_TICK: begin
				if (tmr_on) begin
					if (tmr != 0) begin
						tmr--;
					end
					if (tmr == 0) begin
						drop_latches();
					end
				end
			end
			FUNC_ADD: begin
				if (n_entries >= NE) begin
					r.status = ST_FULL;
				end else begin
					n = n_entries;
					ent_valid[n] = 1'b1;
					ent_key[n] = w.keycode;
					ent_need[n] = w.entry_mask;
					ent_type[n] = w.entry_type;
					ent_tog[n] = w.entry_toggle;
					ent_pressed[n] = 1'b0;
					ent_latched[n] = 1'b0;
					rel_key[n][0] = w.keycode;
					rel_cnt[n] = 1;
					n_entries++;
				end
			end
			FUNC_ADD_REL: begin
				if (n_entries == 0) begin
					r.status = ST_NO_MATCH;
				end else begin
					n = n_entries - 1;
					if (rel_cnt[n] >= NR) begin
						r.status = ST_REL_FULL;
					end else begin
						rel_key[n][rel_cnt[n]] = w.keycode;
						rel_cnt[n]++;
					end
				end
			end
			FUNC_RESET_ST: begin
				ent_pressed = '0;
				drop_latches();
			end
			FUNC_CLEAR: begin
				clear_table();
			end
			default: begin
			end
		endcase
		r.modifier_state = active_mods();
		r.any_toggled = |(ent_valid & ent_tog & ent_latched);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout = TIMEOUT_RESET;
			clear_table();
			expected_words.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					want = expected_words.pop_front();
					if (rsp.status !== want.status) begin
						report_mismatch($sformatf("status: want %0d got %0d",
							want.status, rsp.status));
					end
					if (rsp.modifier_state !== want.modifier_state) begin
						report_mismatch($sformatf("modifier_state: want %04h got %04h",
							want.modifier_state, rsp.modifier_state));
					end
					if (rsp.any_toggled !== want.any_toggled) begin
						report_mismatch($sformatf("any_toggled: want %0b got %0b",
							want.any_toggled, rsp.any_toggled));
					end
				end
			end
			if (req_valid && !req_stall) begin
				expected_words.push_back(track_word(req));
			end
			if (cfg_wr_en) begin
				timeout = cfg_wr_data;
			end
		end
		outstanding = expected_words.size();
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import smk_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	req_t        req = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	rsp_t        rsp;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;

	int          errors;
	int          outstanding;
	int          idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_go = 1'b0;
	logic [15:0] key_pool [6];

	sticky_modifier_key_tracker_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	smk_result_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.errors     (errors),
		.outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stall, or one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic req_t mk(input func_e f, input logic [15:0] k, input logic [2:0] h,
			input logic [3:0] t, input logic [15:0] m, input logic g);
		req_t w;
		w.func = f;
		w.keycode = k;
		w.held_modifiers = h;
		w.entry_type = t;
		w.entry_mask = m;
		w.entry_toggle = g;
		return w;
	endfunction

	function automatic logic [15:0] pick_key(input int pct_pool);
		if ($urandom_range(99) < pct_pool) begin
			return key_pool[$urandom_range(5)];
		end
		return 16'($urandom);
	endfunction

	// mostly well-formed table traffic with keys from a small pool
	function automatic req_t random_word();
		req_t w;
		int r;
		w.keycode = 16'($urandom);
		w.held_modifiers = 3'($urandom);
		w.entry_type = 4'($urandom);
		w.entry_mask = 16'($urandom);
		w.entry_toggle = 1'($urandom);
		r = $urandom_range(99);
		if (r < 34) begin
			w.func = FUNC_PRESS;
			w.keycode = pick_key(85);
		end else if (r < 54) begin
			w.func = FUNC_RELEASE;
			w.keycode = pick_key(85);
		end else if (r < 72) begin
			w.func = FUNC_TICK;
		end else if (r < 84) begin
			w.func = FUNC_ADD;
			w.keycode = pick_key(90);
			if ($urandom_range(4) != 0) begin
				w.entry_type = 4'($urandom_range(7));
			end
			case ($urandom_range(3))
				0: w.entry_mask = '0;
				1: w.entry_mask = 16'($urandom_range(7));
				2: w.entry_mask = 16'd1 << $urandom_range(7);
				default: begin
				end
			endcase
		end else if (r < 91) begin
			w.func = FUNC_ADD_REL;
			w.keycode = pick_key(70);
		end else if (r < 95) begin
			w.func = FUNC_RESET_ST;
		end else if (r < 98) begin
			w.func = FUNC_CLEAR;
		end else begin
			w.func = FUNC_NOP;
		end
		return w;
	endfunction

	task automatic push_word(input req_t w);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_timeout(input logic [23:0] v);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int n, input logic [23:0] tmo, input int idle,
			input int stall, input bit squeeze);
		write_timeout(tmo);
		idle_pct = idle;
		stall_pct = stall;
		foreach (key_pool[i]) begin
			key_pool[i] = 16'($urandom);
		end
		if (squeeze) begin
			hold_go = 1'b1;
		end
		repeat (n) push_word(random_word());
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: short timeout so a latch expires within a few ticks
		write_timeout(24'd3);
		push_word(mk(FUNC_ADD_REL, 16'h1111, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_PRESS, 16'h0000, 3'd7, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_TICK, 16'h0000, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_NOP, 16'hFFFF, 3'd7, 4'd15, 16'hFFFF, 1'b1));
		push_word(mk(FUNC_ADD, 16'hFFFF, 3'd0, 4'd0, 16'h0000, 1'b1));
		push_word(mk(FUNC_ADD_REL, 16'h0000, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_ADD_REL, 16'h1234, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_ADD, 16'h0000, 3'd0, 4'd15, 16'hFFFF, 1'b0));
		push_word(mk(FUNC_PRESS, 16'h0000, 3'd7, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_ADD, 16'h0041, 3'd0, 4'd1, 16'h0001, 1'b0));
		push_word(mk(FUNC_PRESS, 16'h0041, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_PRESS, 16'h0041, 3'd1, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_PRESS, 16'hFFFF, 3'd0, 4'd0, 16'h0000, 1'b0));
		repeat (3) push_word(mk(FUNC_TICK, 16'h0000, 3'd0, 4'd0, 16'h0000, 1'b0));
		// latch on, then off again: timer stops
		repeat (2) push_word(mk(FUNC_PRESS, 16'hFFFF, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_RELEASE, 16'h0000, 3'd0, 4'd0, 16'h0000, 1'b0));
		push_word(mk(FUNC_RESET_ST, 16'h0000, 3'd0, 4'd0, 16'h0000, 1'b0));
		for (int i = 0; i < 6; i++) begin
			push_word(mk(FUNC_ADD, 16'h8000 + 16'(i), 3'd0, 4'(4 + i), 16'h0010, 1'b1));
		end
		push_word(mk(FUNC_CLEAR, 16'h0000, 3'd0, 4'd0, 16'h0000, 1'b0));

		run_random(200, 24'hFFFFFF, 0, 0, 1'b0);
		run_random(200, 24'd0, 76, 0, 1'b0);
		run_random(250, 24'd2, 0, 76, 1'b0);
		run_random(250, 24'd5, 9, 9, 1'b0);
		run_random(150, 24'd1, 0, 0, 1'b1);
		run_random(150, TIMEOUT_RESET, 30, 30, 1'b0);

		wait_idle();
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/smk_pkg.sv
sv/smk_cell.sv
sv/sticky_modifier_key_tracker_unit.sv
bench/smk_result_checker.sv
bench/tb.sv
